[rtl/core/tspbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspbb_pkg
// Shared constants and controller/datapath interface types for the
// branch-and-bound tour search.
// ----------------------------------------------------------------------------
package tspbb_pkg;

  localparam int MAX_CITIES = 16;
  localparam int CITY_W     = 4;
  localparam int CNT_W      = 5;
  localparam int DIST_W     = 16;
  localparam int COST_W     = 20;
  localparam int ADDR_W     = 2 * CITY_W;

  localparam logic [COST_W-1:0] COST_MAX   = {COST_W{1'b1}};
  localparam logic [CNT_W-1:0]  N_MIN      = CNT_W'(2);
  localparam logic [CNT_W-1:0]  N_MAX      = CNT_W'(MAX_CITIES);
  localparam logic [CNT_W-1:0]  N_RESET    = CNT_W'(5);
  localparam logic              FUNC_LOAD  = 1'b0;
  localparam logic              FUNC_SOLVE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic init;
    logic skip;
    logic rd_edge;
    logic rd_close;
    logic descend;
    logic backtrack;
    logic accept;
    logic emit_init;
    logic emit_rd;
    logic emit_load;
    logic emit_next;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_func;
    logic start_ok;
    logic cand_ge_n;
    logic lv_zero;
    logic skip;
    logic cost_lt_best;
    logic last_level;
    logic closed_lt_best;
    logic tour_valid;
    logic out_valid;
    logic emit_last;
  } dp_sts_t;

endpackage

[rtl/core/tspbb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspbb_ctrl
// Sequencer for loads, the depth-first search and the tour word output.
// ----------------------------------------------------------------------------
module tspbb_ctrl
  import tspbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_stall,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_EDGE, S_CLOSE, S_EMIT_RD, S_EMIT_WAIT, S_EMIT_HOLD
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   out_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = sts.out_valid && !out_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (sts.in_func == FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else if (sts.start_ok) begin
            cmd.init   = 1'b1;
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (sts.cand_ge_n) begin
          if (!sts.lv_zero) begin
            cmd.backtrack = 1'b1;
          end else if (sts.tour_valid) begin
            cmd.emit_init = 1'b1;
            state_next    = S_EMIT_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else if (sts.skip) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.rd_edge = 1'b1;
          state_next  = S_EDGE;
        end
      end
      S_EDGE: begin
        state_next = S_EVAL;
        if (sts.cost_lt_best) begin
          if (sts.last_level) begin
            cmd.rd_close = 1'b1;
            state_next   = S_CLOSE;
          end else begin
            cmd.descend = 1'b1;
          end
        end
      end
      S_CLOSE: begin
        cmd.accept = sts.closed_lt_best;
        state_next = S_EVAL;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        cmd.emit_load = 1'b1;
        state_next    = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        if (out_take) begin
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/tspbb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspbb_dp
// Distance memory, search stack, best tour store and output word register.
// ----------------------------------------------------------------------------
module tspbb_dp
  import tspbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              func,
  input  logic [CITY_W-1:0] row,
  input  logic [CITY_W-1:0] col,
  input  logic [DIST_W-1:0] distance,
  input  logic [CITY_W-1:0] start_city,
  input  logic              out_stall,
  input  ctrl_cmd_t         cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  output logic [CITY_W-1:0] from_city,
  output logic [CITY_W-1:0] to_city,
  output logic [DIST_W-1:0] edge_length,
  output logic [COST_W-1:0] total_cost,
  output logic              last
);

  logic [CNT_W-1:0]      n_cities;
  logic [CNT_W-1:0]      n_eff;
  logic [DIST_W-1:0]     dist_mem [MAX_CITIES*MAX_CITIES];
  logic [DIST_W-1:0]     rd_q;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_en;

  logic [CITY_W-1:0]     lv;
  logic [CITY_W-1:0]     lv_m1;
  logic [CNT_W-1:0]      cand;
  logic [COST_W-1:0]     partial;
  logic [CITY_W-1:0]     nx;
  logic [COST_W-1:0]     cost_reg;
  logic [COST_W-1:0]     best;
  logic [CITY_W-1:0]     start;
  logic [MAX_CITIES-1:0] visited;
  logic                  tour_valid;
  logic [CITY_W-1:0]     path      [MAX_CITIES];
  logic [CNT_W-1:0]      cand_stk  [MAX_CITIES];
  logic [COST_W-1:0]     cost_stk  [MAX_CITIES];
  logic [CITY_W-1:0]     best_tour [MAX_CITIES];
  logic [CITY_W-1:0]     cur;

  logic [CITY_W-1:0]     k;
  logic [CNT_W-1:0]      k_p1;
  logic [CITY_W-1:0]     from_reg;
  logic [CITY_W-1:0]     to_reg;
  logic [CITY_W-1:0]     to_sel;

  logic [COST_W:0]       sum_edge;
  logic [COST_W:0]       sum_close;
  logic [COST_W-1:0]     cost;
  logic [COST_W-1:0]     closed;

  // effective city count, clamped to the supported range
  always_comb begin
    if (n_cities < N_MIN) begin
      n_eff = N_MIN;
    end else if (n_cities > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = n_cities;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_cities <= N_RESET;
    end else if (cfg_wr_en) begin
      n_cities <= cfg_wr_data;
    end
  end

  assign cur    = path[lv];
  assign lv_m1  = lv - 1'b1;
  assign k_p1   = {1'b0, k} + 1'b1;
  assign to_sel = (k_p1 == n_eff) ? best_tour[0] : best_tour[k_p1[CITY_W-1:0]];

  // distance memory read address
  always_comb begin
    rd_en   = cmd.rd_edge | cmd.rd_close | cmd.emit_rd;
    rd_addr = {from_reg, to_sel};
    if (cmd.rd_edge) begin
      rd_addr = {cur, cand[CITY_W-1:0]};
    end else if (cmd.rd_close) begin
      rd_addr = {nx, start};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && ({1'b0, row} < n_eff) && ({1'b0, col} < n_eff)) begin
      dist_mem[{row, col}] <= distance;
    end
    if (rd_en) begin
      rd_q <= dist_mem[rd_addr];
    end
  end

  // saturating cost sums
  assign sum_edge  = {1'b0, partial} + {{(COST_W-DIST_W+1){1'b0}}, rd_q};
  assign cost      = sum_edge[COST_W] ? COST_MAX : sum_edge[COST_W-1:0];
  assign sum_close = {1'b0, cost_reg} + {{(COST_W-DIST_W+1){1'b0}}, rd_q};
  assign closed    = sum_close[COST_W] ? COST_MAX : sum_close[COST_W-1:0];

  // status
  always_comb begin
    sts.in_func        = func;
    sts.start_ok       = ({1'b0, start_city} < n_eff);
    sts.cand_ge_n      = (cand >= n_eff);
    sts.lv_zero        = (lv == '0);
    sts.skip           = (cand == {1'b0, cur}) || visited[cand[CITY_W-1:0]];
    sts.cost_lt_best   = (cost < best);
    sts.last_level     = (({1'b0, lv} + CNT_W'(2)) == n_eff);
    sts.closed_lt_best = (closed < best);
    sts.tour_valid     = tour_valid;
    sts.out_valid      = out_valid;
    sts.emit_last      = (k_p1 == n_eff);
  end

  // search control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lv         <= '0;
      cand       <= '0;
      visited    <= '0;
      tour_valid <= 1'b0;
      best       <= COST_MAX;
    end else begin
      if (cmd.init) begin
        lv         <= '0;
        cand       <= '0;
        visited    <= MAX_CITIES'(1) << start_city;
        tour_valid <= 1'b0;
        best       <= COST_MAX;
      end
      if (cmd.skip) begin
        cand <= cand + 1'b1;
      end
      if (cmd.rd_edge) begin
        cand <= cand + 1'b1;
      end
      if (cmd.descend) begin
        lv          <= lv + 1'b1;
        cand        <= '0;
        visited[nx] <= 1'b1;
      end
      if (cmd.backtrack) begin
        lv           <= lv_m1;
        cand         <= cand_stk[lv_m1];
        visited[cur] <= 1'b0;
      end
      if (cmd.accept) begin
        best       <= closed;
        tour_valid <= 1'b1;
      end
    end
  end

  // search payload: path, stack and best tour
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      start   <= start_city;
      path[0] <= start_city;
      partial <= '0;
    end
    if (cmd.rd_edge) begin
      nx <= cand[CITY_W-1:0];
    end
    if (cmd.rd_close) begin
      cost_reg <= cost;
    end
    if (cmd.descend) begin
      cand_stk[lv]        <= cand;
      cost_stk[lv]        <= partial;
      path[lv + 1'b1]     <= nx;
      partial             <= cost;
    end
    if (cmd.backtrack) begin
      partial <= cost_stk[lv_m1];
    end
    if (cmd.accept) begin
      for (int i = 0; i < MAX_CITIES; i++) begin
        best_tour[i] <= (CITY_W'(i) == lv + 1'b1) ? nx : path[i];
      end
    end
  end

  // tour word output
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      k        <= '0;
      from_reg <= best_tour[0];
    end
    if (cmd.emit_rd) begin
      to_reg <= to_sel;
    end
    if (cmd.emit_next) begin
      k        <= k + 1'b1;
      from_reg <= to_reg;
    end
    if (cmd.emit_load) begin
      from_city   <= from_reg;
      to_city     <= to_reg;
      edge_length <= rd_q;
      total_cost  <= best;
      last        <= (k_p1 == n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/tsp_branch_and_bound_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_branch_and_bound_search
// Exhaustive depth-first branch-and-bound tour search over a loaded matrix.
// ----------------------------------------------------------------------------
// A load word (func 0) writes one distance, so loads stream one per cycle.
// A solve word (func 1) holds in_stall high for the whole search and the
// tour output: each candidate city is either skipped or has its edge read
// from the distance memory (and its closing edge too when it completes a
// tour), so solve time grows with the number of branches explored, roughly
// factorially in the effective city count. The best tour, if one was found,
// then leaves as one word per effective city, each held while out_stall is high.
// ----------------------------------------------------------------------------
module tsp_branch_and_bound_search
  import tspbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [CITY_W-1:0] row,
  input  logic [CITY_W-1:0] col,
  input  logic [DIST_W-1:0] distance,
  input  logic [CITY_W-1:0] start_city,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CITY_W-1:0] from_city,
  output logic [CITY_W-1:0] to_city,
  output logic [DIST_W-1:0] edge_length,
  output logic [COST_W-1:0] total_cost,
  output logic              last
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tspbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tspbb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .func        (func),
    .row         (row),
    .col         (col),
    .distance    (distance),
    .start_city  (start_city),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .from_city   (from_city),
    .to_city     (to_city),
    .edge_length (edge_length),
    .total_cost  (total_cost),
    .last        (last)
  );

endmodule

[rtl/core/tspbb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspbb_checker
// Port-level checks on the tour word output of the search block.
// ----------------------------------------------------------------------------
module tspbb_checker
  import tspbb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CITY_W-1:0] from_city,
  input logic [CITY_W-1:0] to_city,
  input logic              last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(from_city) && $stable(to_city))
    else $error("stalled output word changed");

  // words only leave while input is stalled
  a_out_in_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("output word while input open");

  // nothing follows the closing edge
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid && !in_stall)
    else $error("word after closing edge");

  // each taken word is followed by a gap
  a_word_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("back-to-back words");

endmodule

bind tsp_branch_and_bound_search tspbb_checker u_tspbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .from_city (from_city),
  .to_city   (to_city),
  .last      (last)
);

[tb/tb_tsp_branch_and_bound_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tsp_branch_and_bound_search
// Self-checking bench for the branch-and-bound tour search. Distance words
// and solve words are pushed with random gaps while the output side stalls
// at random. An in-bench tour solver predicts every tour edge word, and a
// monitor checks each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tsp_branch_and_bound_search;
  import tspbb_pkg::*;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int RANDOM_WORDS    = 80;

  typedef struct {
    logic [CITY_W-1:0] from_city;
    logic [CITY_W-1:0] to_city;
    logic [DIST_W-1:0] edge_length;
    logic [COST_W-1:0] total_cost;
    logic              last;
  } tour_edge_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              func;
  logic [CITY_W-1:0] row;
  logic [CITY_W-1:0] col;
  logic [DIST_W-1:0] distance;
  logic [CITY_W-1:0] start_city;
  logic              out_valid;
  logic              out_stall;
  logic [CITY_W-1:0] from_city;
  logic [CITY_W-1:0] to_city;
  logic [DIST_W-1:0] edge_length;
  logic [COST_W-1:0] total_cost;
  logic              last;

  // bench copy of the block state
  logic [DIST_W-1:0] dist_mem [MAX_CITIES][MAX_CITIES];
  bit                dist_written [MAX_CITIES][MAX_CITIES];
  int                cities_eff;
  tour_edge_t        tour_edges_q[$];

  int  errors;
  int  words_sent;
  int  solves_sent;
  int  edges_seen;
  int  idle_cycles;
  int  out_hold;
  bit  quiet;

  tsp_branch_and_bound_search dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .row         (row),
    .col         (col),
    .distance    (distance),
    .start_city  (start_city),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .from_city   (from_city),
    .to_city     (to_city),
    .edge_length (edge_length),
    .total_cost  (total_cost),
    .last        (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int sat_cost(int a, int b);
    int s;
    s = a + b;
    return (s > int'(COST_MAX)) ? int'(COST_MAX) : s;
  endfunction

  // exhaustive branch-and-bound, queues the best tour's edges
  task automatic solve_tour(int n, int s);
    bit used [MAX_CITIES][MAX_CITIES];
    int path [MAX_CITIES];
    int cand [MAX_CITIES];
    int cost_at [MAX_CITIES];
    int best_path [MAX_CITIES];
    int best, lv, cur, nx, cost, closed, k, a, b;
    bit found, seen;
    tour_edge_t e;
    foreach (used[i, j]) used[i][j] = 1'b0;
    best = int'(COST_MAX);
    found = 1'b0;
    lv = 0;
    path[0] = s;
    cost_at[0] = 0;
    cand[0] = 0;
    forever begin
      cur = path[lv];
      if (cand[lv] >= n) begin
        if (lv == 0) break;
        lv--;
        a = path[lv];
        b = path[lv + 1];
        used[a][b] = 1'b0;
        used[b][a] = 1'b0;
        continue;
      end
      nx = cand[lv];
      cand[lv] = nx + 1;
      seen = 1'b0;
      for (k = 0; k <= lv; k++) if (path[k] == nx) seen = 1'b1;
      if (nx == cur || used[cur][nx] || seen) continue;
      cost = sat_cost(cost_at[lv], dist_mem[cur][nx]);
      if (!(cost < best)) continue;
      if (lv + 2 == n) begin
        closed = sat_cost(cost, dist_mem[nx][s]);
        if (closed < best) begin
          best = closed;
          for (k = 0; k <= lv; k++) best_path[k] = path[k];
          best_path[lv + 1] = nx;
          found = 1'b1;
        end
      end else begin
        used[cur][nx] = 1'b1;
        used[nx][cur] = 1'b1;
        path[lv + 1] = nx;
        cost_at[lv + 1] = cost;
        cand[lv + 1] = 0;
        lv++;
      end
    end
    if (found) begin
      for (k = 0; k < n; k++) begin
        e.from_city   = CITY_W'(best_path[k]);
        e.to_city     = CITY_W'(best_path[(k + 1) % n]);
        e.edge_length = dist_mem[best_path[k]][best_path[(k + 1) % n]];
        e.total_cost  = COST_W'(best);
        e.last        = (k + 1 == n);
        tour_edges_q.push_back(e);
      end
    end
  endtask

  // send one word; starts and ends at a falling edge
  task automatic send_word(logic f, int r, int c, int d, int s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    row        <= CITY_W'(r);
    col        <= CITY_W'(c);
    distance   <= DIST_W'(d);
    start_city <= CITY_W'(s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (f == FUNC_LOAD) begin
      if (r < cities_eff && c < cities_eff) begin
        dist_mem[r][c] = DIST_W'(d);
        dist_written[r][c] = 1'b1;
      end
    end else begin
      solves_sent++;
      if (s < cities_eff) solve_tour(cities_eff, s);
    end
    @(negedge clk);
  endtask

  function automatic int rand_dist();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 16'hFFFF - $urandom_range(0, 15);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // load every off-diagonal entry not yet written that a search could read
  task automatic fill_matrix();
    for (int r = 0; r < cities_eff; r++)
      for (int c = 0; c < cities_eff; c++)
        if (r != c && !dist_written[r][c]) send_word(FUNC_LOAD, r, c, rand_dist(), 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tour_edges_q.size() != 0 || in_stall) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_cities(int v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cities_eff = (v < 2) ? 2 : ((v > MAX_CITIES) ? MAX_CITIES : v);
  endtask

  task automatic test_default_size();
    quiet = 1'b0;
    send_word(FUNC_LOAD, 0, 1, 16'hFFFF, 0);
    send_word(FUNC_LOAD, 1, 0, 16'h0000, 0);
    fill_matrix();
    send_word(FUNC_LOAD, 5, 2, 16'h1234, 0);
    send_word(FUNC_LOAD, 2, 15, 16'h1234, 0);
    send_word(FUNC_SOLVE, 0, 0, 0, 0);
    send_word(FUNC_SOLVE, 0, 0, 0, 4);
    send_word(FUNC_SOLVE, 0, 0, 0, 5);
  endtask

  task automatic test_size_extremes();
    write_cities(0);
    fill_matrix();
    send_word(FUNC_SOLVE, 0, 0, 0, 1);
    write_cities(1);
    send_word(FUNC_SOLVE, 0, 0, 0, 0);
    // all-zero matrix keeps the full-size search short: first tour prunes all
    write_cities(31);
    quiet = 1'b1;
    for (int r = 0; r < MAX_CITIES; r++)
      for (int c = 0; c < MAX_CITIES; c++)
        if (r != c) send_word(FUNC_LOAD, r, c, 0, 0);
    send_word(FUNC_SOLVE, 0, 0, 0, 15);
    quiet = 1'b0;
    write_cities(16);
    send_word(FUNC_SOLVE, 0, 0, 0, 7);
  endtask

  task automatic test_drain_pause();
    write_cities(4);
    fill_matrix();
    send_word(FUNC_SOLVE, 0, 0, 0, 2);
    // hold the sender until the whole tour is out
    in_valid <= 1'b0;
    while (tour_edges_q.size() != 0) @(negedge clk);
    send_word(FUNC_LOAD, 2, 3, rand_dist(), 0);
    send_word(FUNC_SOLVE, 0, 0, 0, 3);
  endtask

  task automatic test_random_traffic();
    int sent, sel, r, c, v;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      sel = $urandom_range(0, 9);
      v = (sel < 2) ? $urandom_range(0, 3) : ((sel < 9) ? $urandom_range(3, 5) : 6);
      if ($urandom_range(0, 9) == 0) v = 7;
      write_cities(v);
      quiet = ($urandom_range(0, 3) == 0);
      fill_matrix();
      for (int i = 0; i < 30; i++) begin
        sel = $urandom_range(0, 19);
        if (sel < 15) begin
          r = $urandom_range(0, cities_eff - 1);
          c = $urandom_range(0, cities_eff - 1);
          send_word(FUNC_LOAD, r, c, rand_dist(), $urandom_range(0, 15));
          sent++;
        end else if (sel < 17) begin
          // ignored load, outside the active cities
          r = $urandom_range(cities_eff, 15);
          c = $urandom_range(0, 15);
          if ($urandom_range(0, 1)) send_word(FUNC_LOAD, r, c, rand_dist(), 0);
          else send_word(FUNC_LOAD, c, r, rand_dist(), 0);
        end else begin
          v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                          : $urandom_range(0, cities_eff - 1);
          send_word(FUNC_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 65535), v);
          sent++;
        end
      end
    end
  endtask

  // output stall pattern, one hold time drawn per word
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold  <= out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    tour_edge_t e;
    if (!rst && out_valid && !out_stall) begin
      edges_seen++;
      out_hold <= $urandom_range(0, 17);
      if (tour_edges_q.size() == 0) begin
        $error("unexpected tour word from %0d to %0d", from_city, to_city);
        errors++;
      end else begin
        e = tour_edges_q.pop_front();
        if (from_city !== e.from_city) begin
          $error("from_city expected %0d actual %0d", e.from_city, from_city);
          errors++;
        end
        if (to_city !== e.to_city) begin
          $error("to_city expected %0d actual %0d", e.to_city, to_city);
          errors++;
        end
        if (edge_length !== e.edge_length) begin
          $error("edge_length expected %0h actual %0h", e.edge_length, edge_length);
          errors++;
        end
        if (total_cost !== e.total_cost) begin
          $error("total_cost expected %0h actual %0h", e.total_cost, total_cost);
          errors++;
        end
        if (last !== e.last) begin
          $error("last expected %0b actual %0b", e.last, last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout with %0d tour words pending", tour_edges_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    func = FUNC_LOAD;
    row = '0;
    col = '0;
    distance = '0;
    start_city = '0;
    out_stall = 1'b0;
    out_hold = 0;
    quiet = 1'b0;
    errors = 0;
    words_sent = 0;
    solves_sent = 0;
    edges_seen = 0;
    idle_cycles = 0;
    cities_eff = N_RESET;
    foreach (dist_written[i, j]) dist_written[i][j] = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_default_size();
    test_size_extremes();
    test_drain_pause();
    test_random_traffic();
    drain();

    if (tour_edges_q.size() != 0) begin
      $error("%0d tour words never arrived", tour_edges_q.size());
      errors++;
    end
    $display("sent %0d words including %0d solves, checked %0d tour words",
             words_sent, solves_sent, edges_seen);
    $display("city counts from 2 to 16 with clamped register values, random gaps and stalls");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
